// ===== hw/rtl/zhp_pkg.sv =====
// -----------------------------------------------------------------------------
// zhp_pkg
// Types and constants shared by the frame and block header parser.
// -----------------------------------------------------------------------------
`default_nettype none
package zhp_pkg;

  localparam int unsigned RecKindW = 2;

  localparam logic [1:0] REC_FRAME = 2'd0;
  localparam logic [1:0] REC_BLOCK = 2'd1;
  localparam logic [1:0] REC_LIT   = 2'd2;
  localparam logic [1:0] REC_SEQ   = 2'd3;

  localparam logic [1:0] BLK_RAW  = 2'd0;
  localparam logic [1:0] BLK_RLE  = 2'd1;
  localparam logic [1:0] BLK_COMP = 2'd2;

  localparam logic [63:0] SeqLongBase = 64'd32512;

  typedef struct packed {
    logic [1:0]  rec_kind;
    logic        flag_a;
    logic        flag_b;
    logic [1:0]  type_code;
    logic [1:0]  format_code;
    logic [63:0] size_main;
    logic [43:0] size_second;
    logic [31:0] dictionary_id;
    logic [1:0]  literal_len_mode;
    logic [1:0]  offset_mode;
    logic [1:0]  match_len_mode;
  } rec_t;

  // Raw header record fields; window size is expanded in the back end.
  typedef struct packed {
    logic [1:0]  rec_kind;
    logic        flag_a;
    logic        flag_b;
    logic [1:0]  type_code;
    logic [1:0]  format_code;
    logic [63:0] size_main;
    logic [43:0] size_second;
    logic [31:0] dictionary_id;
    logic [1:0]  literal_len_mode;
    logic [1:0]  offset_mode;
    logic [1:0]  match_len_mode;
    logic        win_present;
    logic [7:0]  win_byte;
  } raw_rec_t;

endpackage
`default_nettype wire

// ===== hw/rtl/zhp_byte_if.sv =====
// -----------------------------------------------------------------------------
// zhp_byte_if
// Valid/ready channel carrying one frame byte.
// -----------------------------------------------------------------------------
`default_nettype none
interface zhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/zhp_rec_if.sv =====
// -----------------------------------------------------------------------------
// zhp_rec_if
// Valid/ready channel carrying one header record.
// -----------------------------------------------------------------------------
`default_nettype none
interface zhp_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  rec_kind;
  logic        flag_a;
  logic        flag_b;
  logic [1:0]  type_code;
  logic [1:0]  format_code;
  logic [63:0] size_main;
  logic [43:0] size_second;
  logic [31:0] dictionary_id;
  logic [1:0]  literal_len_mode;
  logic [1:0]  offset_mode;
  logic [1:0]  match_len_mode;
  modport source (output valid, output rec_kind, output flag_a, output flag_b,
                  output type_code, output format_code, output size_main,
                  output size_second, output dictionary_id,
                  output literal_len_mode, output offset_mode,
                  output match_len_mode, input ready);
  modport sink   (input valid, input rec_kind, input flag_a, input flag_b,
                  input type_code, input format_code, input size_main,
                  input size_second, input dictionary_id,
                  input literal_len_mode, input offset_mode,
                  input match_len_mode, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/zhp_front.sv =====
// -----------------------------------------------------------------------------
// zhp_front
// Byte parser: tracks the frame layout and produces raw header records.
// -----------------------------------------------------------------------------
`default_nettype none
module zhp_front
  import zhp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] stream_length_i,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output raw_rec_t         rec_o,
  output logic             rec_vld_o
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_DESC, PH_FREST, PH_BHDR, PH_TRAIL,
    PH_SKIP, PH_LHDR, PH_LSKIP, PH_SHDR, PH_SMODE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [63:0] gath_q, gath_d;
  logic [31:0] cons_q, cons_d;
  logic [21:0] blk_q, blk_d;
  logic [21:0] skip_q, skip_d;
  logic [7:0]  desc_q, desc_d;
  logic [63:0] hold_q, hold_d;

  logic [3:0]  idx_n;
  logic [63:0] g;
  logic [2:0]  wl, dl;
  logic [3:0]  fl, tot;
  logic [31:0] total;
  logic [21:0] blk_dec;
  logic [7:0]  b0;
  logic [63:0] reg_v, cnt;
  logic [43:0] comp_v;
  logic [3:0]  need;
  logic [5:0]  sh;

  always_comb begin
    wl = desc_q[5] ? 3'd0 : 3'd1;
    dl = (desc_q[1:0] == 2'd3) ? 3'd4 : {1'b0, desc_q[1:0]};
    case (desc_q[7:6])
      2'd0:    fl = desc_q[5] ? 4'd1 : 4'd0;
      2'd1:    fl = 4'd2;
      2'd2:    fl = 4'd4;
      default: fl = 4'd8;
    endcase
    tot = {1'b0, wl} + {1'b0, dl} + fl;
  end

  function automatic raw_rec_t frame_rec(logic [7:0] d, logic [63:0] gr, logic [63:0] h);
    raw_rec_t r;
    r = '0;
    r.rec_kind      = REC_FRAME;
    r.flag_a        = d[2];
    r.flag_b        = d[5];
    r.type_code     = d[1:0];
    r.format_code   = d[7:6];
    r.size_main     = (d[7:6] == 2'd1) ? gr + 64'd256 : gr;
    r.dictionary_id = h[31:0];
    r.win_present   = ~d[5];
    r.win_byte      = h[39:32];
    return r;
  endfunction

  always_comb begin
    phase_d = phase_q; idx_d = idx_q; gath_d = gath_q; cons_d = cons_q;
    blk_d = blk_q; skip_d = skip_q; desc_d = desc_q; hold_d = hold_q;
    rec_o = '0; rec_vld_o = 1'b0;
    idx_n = idx_q + 4'd1;
    g = gath_q | ({56'd0, byte_i} << {idx_q[2:0], 3'b000});
    total = stream_length_i;
    if (desc_q[2]) total = (stream_length_i >= 32'd4) ? stream_length_i - 32'd4 : '0;
    blk_dec = blk_q - 22'd1;
    b0 = g[7:0];
    reg_v = '0; comp_v = '0; cnt = '0; need = 4'd1; sh = '0;
    if (step_i) begin
      if (cons_q != 32'hFFFF_FFFF) cons_d = cons_q + 32'd1;
      case (phase_q)
        PH_MAGIC: begin
          idx_d = idx_n;
          if (idx_n >= 4'd4) begin idx_d = '0; phase_d = PH_DESC; end
        end
        PH_DESC: begin
          desc_d = byte_i; gath_d = '0; hold_d = '0; idx_d = '0;
          // every descriptor is followed by at least one header byte
          phase_d = PH_FREST;
        end
        PH_FREST: begin
          if (idx_q < {1'b0, wl}) begin
            hold_d = hold_q | ({56'd0, byte_i} << 32);
          end else if (idx_q < {1'b0, wl} + {1'b0, dl}) begin
            sh = {1'b0, idx_q[1:0] - wl[1:0], 3'b000};
            hold_d = hold_q | ({56'd0, byte_i} << sh);
          end else begin
            sh = {idx_q[2:0] - wl - dl, 3'b000};
            gath_d = gath_q | ({56'd0, byte_i} << sh);
          end
          idx_d = idx_n;
          if (idx_n >= tot) begin
            rec_o = frame_rec(desc_q, gath_d, hold_d); rec_vld_o = 1'b1;
            gath_d = '0; idx_d = '0; phase_d = PH_BHDR;
          end
        end
        PH_BHDR: begin
          if (idx_q == 4'd0 && cons_q >= total) begin
            phase_d = PH_TRAIL;
          end else begin
            gath_d = g; idx_d = idx_n;
            if (idx_n >= 4'd3) begin
              rec_o.rec_kind = REC_BLOCK; rec_o.flag_a = b0[0];
              rec_o.type_code = b0[2:1];
              rec_o.size_main = {43'd0, g[23:3]}; rec_vld_o = 1'b1;
              gath_d = '0; idx_d = '0;
              if (b0[2:1] == BLK_RLE) begin
                blk_d = 22'd1; phase_d = PH_SKIP;
              end else begin
                blk_d = {1'b0, g[23:3]};
                if (g[23:3] == 21'd0) phase_d = PH_BHDR;
                else phase_d = (b0[2:1] == BLK_COMP) ? PH_LHDR : PH_SKIP;
              end
            end
          end
        end
        PH_TRAIL: ;
        default: begin
          blk_d = blk_dec;
          case (phase_q)
            PH_LHDR: begin
              gath_d = g; idx_d = idx_n;
              if (b0[1:0] < 2'd2) need = (b0[3:2] == 2'd1) ? 4'd2 :
                                         (b0[3:2] == 2'd3) ? 4'd3 : 4'd1;
              else need = (b0[3:2] < 2'd2) ? 4'd3 : (b0[3:2] == 2'd2) ? 4'd4 : 4'd5;
              if (idx_n >= need) begin
                if (b0[1:0] < 2'd2) begin
                  if (b0[3:2] == 2'd1) reg_v = {52'd0, g[15:4]};
                  else if (b0[3:2] == 2'd3) reg_v = {44'd0, g[23:4]};
                  else reg_v = {59'd0, b0[7:3]};
                  comp_v = (b0[1:0] == 2'd1) ? 44'd1 : reg_v[43:0];
                end else if (b0[3:2] < 2'd2) begin
                  reg_v = {54'd0, g[13:4]}; comp_v = {34'd0, g[23:14]};
                end else if (b0[3:2] == 2'd2) begin
                  reg_v = {50'd0, g[17:4]}; comp_v = {30'd0, g[31:18]};
                end else begin
                  reg_v = {46'd0, g[21:4]}; comp_v = {26'd0, g[39:22]};
                end
                rec_o.rec_kind = REC_LIT; rec_o.type_code = b0[1:0];
                rec_o.format_code = b0[3:2]; rec_o.size_main = reg_v;
                rec_o.size_second = comp_v; rec_vld_o = 1'b1;
                skip_d = comp_v[21:0]; gath_d = '0; idx_d = '0;
                phase_d = (comp_v != '0) ? PH_LSKIP : PH_SHDR;
              end
            end
            PH_LSKIP: begin
              skip_d = skip_q - 22'd1;
              if (skip_d == '0) phase_d = PH_SHDR;
            end
            PH_SHDR: begin
              gath_d = g; idx_d = idx_n;
              need = (b0 < 8'd128) ? 4'd1 : (b0 < 8'd255) ? 4'd2 : 4'd3;
              if (idx_n >= need) begin
                if (b0 < 8'd128) cnt = {56'd0, b0};
                else if (b0 < 8'd255) cnt = {49'd0, b0[6:0], g[15:8]};
                else cnt = {48'd0, g[23:8]} + SeqLongBase;
                gath_d = '0; idx_d = '0;
                if (cnt == '0) begin
                  rec_o.rec_kind = REC_SEQ; rec_vld_o = 1'b1; phase_d = PH_SKIP;
                end else begin
                  hold_d = cnt; phase_d = PH_SMODE;
                end
              end
            end
            PH_SMODE: begin
              rec_o.rec_kind = REC_SEQ; rec_o.size_main = hold_q;
              rec_o.literal_len_mode = byte_i[7:6]; rec_o.offset_mode = byte_i[5:4];
              rec_o.match_len_mode = byte_i[3:2]; rec_vld_o = 1'b1;
              phase_d = PH_SKIP;
            end
            default: ;
          endcase
          if (blk_dec == '0) begin
            phase_d = PH_BHDR; idx_d = '0; gath_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC; idx_q <= '0; gath_q <= '0; cons_q <= '0;
      blk_q <= '0; skip_q <= '0; desc_q <= '0; hold_q <= '0;
    end else begin
      phase_q <= phase_d; idx_q <= idx_d; gath_q <= gath_d; cons_q <= cons_d;
      blk_q <= blk_d; skip_q <= skip_d; desc_q <= desc_d; hold_q <= hold_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/zhp_queue.sv =====
// -----------------------------------------------------------------------------
// zhp_queue
// Two-entry record queue between the parser and the output stage.
// -----------------------------------------------------------------------------
`default_nettype none
module zhp_queue
  import zhp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  raw_rec_t      data_i,
  input  wire logic     pop_i,
  output raw_rec_t      data_o,
  output logic          nempty_o,
  output logic          full_o
);

  raw_rec_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign data_o   = mem_q[rp_q];
  assign nempty_o = cnt_q != 2'd0;
  assign full_o   = cnt_q == 2'd2;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/zhp_back.sv =====
// -----------------------------------------------------------------------------
// zhp_back
// Output stage: expands the window size and holds the outgoing record.
// -----------------------------------------------------------------------------
`default_nettype none
module zhp_back
  import zhp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  raw_rec_t      rec_i,
  input  wire logic     vld_i,
  output logic          pop_o,
  output rec_t          rec_o,
  output logic          vld_o,
  input  wire logic     rdy_i
);

  rec_t  out_q;
  logic  vld_q;
  logic  load;
  logic [43:0] base, b8, win;

  // mantissa times base/8 as shifted adds
  always_comb begin
    base = 44'd1 << (6'd10 + {1'b0, rec_i.win_byte[7:3]});
    b8   = base >> 3;
    win  = base + (rec_i.win_byte[0] ? b8 : 44'd0)
                + (rec_i.win_byte[1] ? (b8 << 1) : 44'd0)
                + (rec_i.win_byte[2] ? (b8 << 2) : 44'd0);
  end

  assign load  = vld_i && (!vld_q || rdy_i);
  assign pop_o = load;
  assign rec_o = out_q;
  assign vld_o = vld_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= rec_t'(rec_i[$bits(raw_rec_t)-1:9]);
      if (rec_i.win_present) out_q.size_second <= win;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (load) vld_q <= 1'b1;
    else if (rdy_i) vld_q <= 1'b0;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/zstd_header_parser.sv =====
// -----------------------------------------------------------------------------
// zstd_header_parser
// Frame, block, literals and sequences header parser for compressed frames.
// -----------------------------------------------------------------------------
// channel   | dir | payload     | meaning
// in_ch     | in  | in_byte     | frame bytes in stream order
// out_ch    | out | record      | one record per completed header
// cfg       | in  | 32-bit data | total frame length
//
// One byte per cycle while the queue has a free entry; a record is written
// to the queue and then to the output register before it is offered.
// Input stalls only once both queue entries are taken, which needs the
// output register to wait on a stalled sink. Reset clears all parse state.
// -----------------------------------------------------------------------------
`default_nettype none
module zstd_header_parser
  import zhp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  zhp_byte_if.sink         in_ch,
  zhp_rec_if.source        out_ch
);

  logic [31:0] len_q;
  logic        step, f_vld, q_ne, q_full, pop;
  raw_rec_t    f_rec, q_rec;
  rec_t        o_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) len_q <= '0;
    else if (cfg_we_i) len_q <= cfg_wdata_i;
  end

  // A byte makes at most one record, so a free entry is enough.
  assign in_ch.ready = !q_full;
  assign step = in_ch.valid && in_ch.ready;

  zhp_front u_front (
    .clk_i, .rst_ni, .stream_length_i(len_q), .step_i(step),
    .byte_i(in_ch.in_byte), .rec_o(f_rec), .rec_vld_o(f_vld)
  );

  zhp_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_vld), .data_i(f_rec), .pop_i(pop),
    .data_o(q_rec), .nempty_o(q_ne), .full_o(q_full)
  );

  zhp_back u_back (
    .clk_i, .rst_ni, .rec_i(q_rec), .vld_i(q_ne), .pop_o(pop),
    .rec_o(o_rec), .vld_o(out_ch.valid), .rdy_i(out_ch.ready)
  );

  assign out_ch.rec_kind         = o_rec.rec_kind;
  assign out_ch.flag_a           = o_rec.flag_a;
  assign out_ch.flag_b           = o_rec.flag_b;
  assign out_ch.type_code        = o_rec.type_code;
  assign out_ch.format_code      = o_rec.format_code;
  assign out_ch.size_main        = o_rec.size_main;
  assign out_ch.size_second      = o_rec.size_second;
  assign out_ch.dictionary_id    = o_rec.dictionary_id;
  assign out_ch.literal_len_mode = o_rec.literal_len_mode;
  assign out_ch.offset_mode      = o_rec.offset_mode;
  assign out_ch.match_len_mode   = o_rec.match_len_mode;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !f_vld) else $error("record queue overflow");
  a_rec_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_vld |-> step) else $error("record without input word");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_ne) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== tb/zstd_header_parser_tb.sv =====
// -----------------------------------------------------------------------------
// testbench
// Drives one frame byte by byte into zstd_header_parser and compares every
// header record with a cycle-free model of the parse. A short directed frame
// opens the run, then random blocks of every type follow, under four
// idle/stall phases. The run closes by letting the frame end through the
// stream length register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import zhp_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC, PH_DESC, PH_FREST, PH_BHDR, PH_TRAIL,
    PH_SKIP, PH_LHDR, PH_LSKIP, PH_SHDR, PH_SMODE
  } phase_e;

  typedef struct {
    logic [7:0] data;
    bit         typed;
    rec_t       rec;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  zhp_byte_if in_if ();
  zhp_rec_if  out_if ();

  zstd_header_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_if.sink),
    .out_ch      (out_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    out_if.ready  = 1'b0;
  end

  // parser model state
  bit [31:0] frame_len;
  phase_e    phase;
  bit [3:0]  hdr_idx;
  bit [63:0] gather;
  bit [31:0] consumed;
  bit [21:0] blk_left;
  bit [21:0] skip_left;
  bit [7:0]  desc;
  bit [63:0] hold;

  rec_t     pending_recs[$];
  logic [7:0] blk_bytes[$];
  row_t     rows[$];
  int       fail_count = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;

  function automatic int win_len();
    return desc[5] ? 0 : 1;
  endfunction

  function automatic int dict_len();
    return desc[1:0] == 2'd3 ? 4 : int'(desc[1:0]);
  endfunction

  function automatic int fcs_len();
    case (desc[7:6])
      2'd0: return desc[5] ? 1 : 0;
      2'd1: return 2;
      2'd2: return 4;
      default: return 8;
    endcase
  endfunction

  function automatic rec_t frame_rec();
    rec_t      r;
    bit [63:0] fcs;
    bit [63:0] base;
    bit [63:0] win;
    bit [7:0]  wb;
    r = '0;
    fcs = gather;
    win = '0;
    if (desc[7:6] == 2'd1) fcs += 64'd256;
    if (win_len() != 0) begin
      wb = hold[39:32];
      base = 64'd1 << (10 + wb[7:3]);
      win = base + (base >> 3) * wb[2:0];
    end
    r.rec_kind      = REC_FRAME;
    r.flag_a        = desc[2];
    r.flag_b        = desc[5];
    r.type_code     = desc[1:0];
    r.format_code   = desc[7:6];
    r.size_main     = fcs;
    r.size_second   = win[43:0];
    r.dictionary_id = hold[31:0];
    return r;
  endfunction

  // one byte through the parse; returns 1 when a record completes
  function automatic bit parse_byte(input logic [7:0] b, output rec_t r);
    bit [31:0] prior;
    bit [31:0] total;
    int        idx;
    int        w;
    int        d;
    int        n;
    bit        hit;
    bit [7:0]  b0;
    bit [1:0]  t;
    bit [1:0]  fm;
    bit [63:0] rsz;
    bit [63:0] comp;
    bit [63:0] cnt;
    r = '0;
    hit = 1'b0;
    prior = consumed;
    idx = hdr_idx;
    if (consumed != 32'hFFFF_FFFF) consumed++;
    case (phase)
      PH_MAGIC: begin
        hdr_idx = 4'(idx + 1);
        if (hdr_idx >= 4) begin
          hdr_idx = 0;
          phase = PH_DESC;
        end
        return 1'b0;
      end
      PH_DESC: begin
        desc = b;
        gather = '0;
        hold = '0;
        hdr_idx = 0;
        if (win_len() + dict_len() + fcs_len() == 0) begin
          r = frame_rec();
          phase = PH_BHDR;
          return 1'b1;
        end
        phase = PH_FREST;
        return 1'b0;
      end
      PH_FREST: begin
        w = win_len();
        d = dict_len();
        if (idx < w) hold |= 64'(b) << 32;
        else if (idx < w + d) hold |= 64'(b) << (8 * ((idx - w) & 3));
        else gather |= 64'(b) << (8 * ((idx - w - d) & 7));
        hdr_idx = 4'(idx + 1);
        if (hdr_idx >= w + d + fcs_len()) begin
          r = frame_rec();
          hit = 1'b1;
          gather = '0;
          hdr_idx = 0;
          phase = PH_BHDR;
        end
        return hit;
      end
      PH_BHDR: begin
        total = frame_len;
        if (desc[2]) total = total >= 4 ? total - 4 : 0;
        if (idx == 0 && prior >= total) begin
          phase = PH_TRAIL;
          return 1'b0;
        end
        gather |= 64'(b) << (8 * (idx & 7));
        hdr_idx = 4'(idx + 1);
        if (hdr_idx >= 3) begin
          b0 = gather[7:0];
          r.rec_kind  = REC_BLOCK;
          r.flag_a    = b0[0];
          r.type_code = b0[2:1];
          r.size_main = 64'(gather[23:3]);
          gather = '0;
          hdr_idx = 0;
          if (b0[2:1] == BLK_RLE) begin
            blk_left = 22'd1;
            phase = PH_SKIP;
          end else begin
            blk_left = r.size_main[21:0];
            if (r.size_main == 0) phase = PH_BHDR;
            else phase = b0[2:1] == BLK_COMP ? PH_LHDR : PH_SKIP;
          end
          return 1'b1;
        end
        return 1'b0;
      end
      PH_TRAIL: return 1'b0;
      default: ;
    endcase

    blk_left = blk_left - 1'b1;
    case (phase)
      PH_LHDR: begin
        gather |= 64'(b) << (8 * (idx & 7));
        hdr_idx = 4'(idx + 1);
        b0 = gather[7:0];
        t = b0[1:0];
        fm = b0[3:2];
        if (t < 2) n = fm == 2'd1 ? 2 : (fm == 2'd3 ? 3 : 1);
        else n = fm < 2 ? 3 : (fm == 2'd2 ? 4 : 5);
        if (hdr_idx >= n) begin
          if (t < 2) begin
            if (fm == 2'd1) rsz = (gather >> 4) & 64'hFFF;
            else if (fm == 2'd3) rsz = (gather >> 4) & 64'hFFFFF;
            else rsz = 64'(b0 >> 3);
            comp = t == 2'd1 ? 64'd1 : rsz;
          end else if (fm < 2) begin
            rsz = (gather >> 4) & 64'h3FF;
            comp = (gather >> 14) & 64'h3FF;
          end else if (fm == 2'd2) begin
            rsz = (gather >> 4) & 64'h3FFF;
            comp = (gather >> 18) & 64'h3FFF;
          end else begin
            rsz = (gather >> 4) & 64'h3FFFF;
            comp = (gather >> 22) & 64'h3FFFF;
          end
          r.rec_kind    = REC_LIT;
          r.type_code   = t;
          r.format_code = fm;
          r.size_main   = rsz;
          r.size_second = comp[43:0];
          hit = 1'b1;
          skip_left = comp[21:0];
          gather = '0;
          hdr_idx = 0;
          phase = comp != 0 ? PH_LSKIP : PH_SHDR;
        end
      end
      PH_LSKIP: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == 0) phase = PH_SHDR;
      end
      PH_SHDR: begin
        gather |= 64'(b) << (8 * (idx & 7));
        hdr_idx = 4'(idx + 1);
        b0 = gather[7:0];
        n = b0 < 128 ? 1 : (b0 < 255 ? 2 : 3);
        if (hdr_idx >= n) begin
          if (b0 < 128) cnt = 64'(b0);
          else if (b0 < 255) cnt = (64'(b0 - 8'd128) << 8) + ((gather >> 8) & 64'hFF);
          else cnt = ((gather >> 8) & 64'hFFFF) + SeqLongBase;
          gather = '0;
          hdr_idx = 0;
          if (cnt == 0) begin
            r.rec_kind = REC_SEQ;
            hit = 1'b1;
            phase = PH_SKIP;
          end else begin
            hold = cnt;
            phase = PH_SMODE;
          end
        end
      end
      PH_SMODE: begin
        r.rec_kind         = REC_SEQ;
        r.size_main        = hold;
        r.literal_len_mode = b[7:6];
        r.offset_mode      = b[5:4];
        r.match_len_mode   = b[3:2];
        hit = 1'b1;
        phase = PH_SKIP;
      end
      default: ;
    endcase
    if (blk_left == 0) begin
      phase = PH_BHDR;
      hdr_idx = 0;
      gather = '0;
    end
    return hit;
  endfunction

  function automatic void compare_rec(rec_t e, rec_t a);
    if (e.rec_kind != a.rec_kind) begin
      $error("rec_kind: expected %0d, got %0d", e.rec_kind, a.rec_kind);
      fail_count++;
    end
    if (e.flag_a != a.flag_a) begin
      $error("flag_a: expected %0d, got %0d", e.flag_a, a.flag_a);
      fail_count++;
    end
    if (e.flag_b != a.flag_b) begin
      $error("flag_b: expected %0d, got %0d", e.flag_b, a.flag_b);
      fail_count++;
    end
    if (e.type_code != a.type_code) begin
      $error("type_code: expected %0d, got %0d", e.type_code, a.type_code);
      fail_count++;
    end
    if (e.format_code != a.format_code) begin
      $error("format_code: expected %0d, got %0d", e.format_code, a.format_code);
      fail_count++;
    end
    if (e.size_main != a.size_main) begin
      $error("size_main: expected %h, got %h", e.size_main, a.size_main);
      fail_count++;
    end
    if (e.size_second != a.size_second) begin
      $error("size_second: expected %h, got %h", e.size_second, a.size_second);
      fail_count++;
    end
    if (e.dictionary_id != a.dictionary_id) begin
      $error("dictionary_id: expected %h, got %h", e.dictionary_id, a.dictionary_id);
      fail_count++;
    end
    if (e.literal_len_mode != a.literal_len_mode) begin
      $error("literal_len_mode: expected %0d, got %0d", e.literal_len_mode,
             a.literal_len_mode);
      fail_count++;
    end
    if (e.offset_mode != a.offset_mode) begin
      $error("offset_mode: expected %0d, got %0d", e.offset_mode, a.offset_mode);
      fail_count++;
    end
    if (e.match_len_mode != a.match_len_mode) begin
      $error("match_len_mode: expected %0d, got %0d", e.match_len_mode, a.match_len_mode);
      fail_count++;
    end
  endfunction

  // record side: random stalls, check against the oldest expectation
  always @(posedge clk_i) begin
    rec_t got;
    if (out_if.valid && out_if.ready) begin
      got.rec_kind         = out_if.rec_kind;
      got.flag_a           = out_if.flag_a;
      got.flag_b           = out_if.flag_b;
      got.type_code        = out_if.type_code;
      got.format_code      = out_if.format_code;
      got.size_main        = out_if.size_main;
      got.size_second      = out_if.size_second;
      got.dictionary_id    = out_if.dictionary_id;
      got.literal_len_mode = out_if.literal_len_mode;
      got.offset_mode      = out_if.offset_mode;
      got.match_len_mode   = out_if.match_len_mode;
      if (pending_recs.size() == 0) begin
        $error("record with no expectation, rec_kind %0d", got.rec_kind);
        fail_count++;
      end else begin
        compare_rec(pending_recs.pop_front(), got);
      end
    end
    if (rst_ni) out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(input logic [7:0] b, input bit typed, input rec_t typed_rec);
    rec_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (parse_byte(b, r)) begin
      if (typed) compare_rec(typed_rec, r);
      pending_recs.push_back(r);
    end
  endtask

  // wait out the records in flight, then write the length register
  task automatic set_frame_len(input logic [31:0] value);
    in_if.valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    frame_len = value;
  endtask

  task automatic add_row(input logic [7:0] b, input bit typed, input rec_t r);
    row_t row;
    row.data = b;
    row.typed = typed;
    row.rec = r;
    rows.push_back(row);
  endtask

  function automatic void push_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) blk_bytes.push_back(v[8*i +: 8]);
  endfunction

  // one random block, mostly well formed
  function automatic void gen_block();
    logic [1:0]  btype;
    logic [20:0] bsize;
    logic [63:0] g;
    logic [1:0]  t;
    logic [1:0]  fm;
    int          comp;
    int          pick;
    int          len;
    blk_bytes.delete();
    pick = $urandom_range(99);
    btype = pick < 60 ? BLK_COMP : (pick < 75 ? BLK_RAW : (pick < 92 ? BLK_RLE : 2'd3));
    if (btype == BLK_RLE) begin
      bsize = 21'($urandom());
      blk_bytes.push_back(8'($urandom()));
    end else if (btype != BLK_COMP) begin
      len = $urandom_range(99) < 3 ? $urandom_range(2000) : $urandom_range(12);
      bsize = 21'(len);
      for (int i = 0; i < len; i++) blk_bytes.push_back(8'($urandom()));
    end else begin
      t = 2'($urandom());
      fm = 2'($urandom());
      comp = $urandom_range(99) < 20 ? 0 : $urandom_range(16);
      if (t == BLK_RLE[1:0]) begin
        if (fm == 2'd1) push_le(64'({$urandom_range(4095), fm, t}), 2);
        else if (fm == 2'd3) push_le(64'({$urandom_range(20'hFFFFF), fm, t}), 3);
        else push_le(64'({$urandom_range(31), 1'b0, t}), 1);
        comp = 1;
      end else if (t == 2'd0) begin
        // raw literals: regenerated size equals skipped size
        if (fm == 2'd1) push_le(64'({comp[11:0], fm, t}), 2);
        else if (fm == 2'd3) push_le(64'({comp[19:0], fm, t}), 3);
        else begin
          comp = comp & 30;
          push_le(64'({comp[4:0], 1'b0, t}), 1);
        end
      end else begin
        g = {$urandom(), $urandom()};
        if (fm < 2) begin
          g = {g[53:14] & 40'h0, comp[9:0], g[9:0], fm, t};
          push_le(g, 3);
        end else if (fm == 2'd2) begin
          g = 64'({comp[13:0], g[13:0], fm, t});
          push_le(g, 4);
        end else begin
          g = 64'({comp[17:0], g[17:0], fm, t});
          push_le(g, 5);
        end
      end
      for (int i = 0; i < comp; i++) blk_bytes.push_back(8'($urandom()));
      pick = $urandom_range(3);
      if (pick == 0) blk_bytes.push_back(8'($urandom_range(127)));
      else if (pick == 1) push_le(64'({8'($urandom()), 8'($urandom_range(128, 254))}), 2);
      else if (pick == 2) push_le(64'({16'($urandom()), 8'hFF}), 3);
      else blk_bytes.push_back(8'h00);
      blk_bytes.push_back(8'($urandom()));
      len = $urandom_range(6);
      for (int i = 0; i < len; i++) blk_bytes.push_back(8'($urandom()));
      bsize = 21'(blk_bytes.size());
      // broken block: may end early, the rest then reads as block headers
      if ($urandom_range(99) < 10) bsize = 21'($urandom_range(blk_bytes.size(), 1));
    end
    g = 64'({bsize, btype, 1'($urandom())});
    blk_bytes.push_front(g[23:16]);
    blk_bytes.push_front(g[15:8]);
    blk_bytes.push_front(g[7:0]);
  endfunction

  initial begin
    automatic rec_t none = '0;
    automatic int sent = 0;
    automatic int pct_idle[4] = '{0, 81, 0, 21};
    automatic int pct_stall[4] = '{0, 0, 81, 21};
    frame_len = '0;
    phase = PH_MAGIC;
    hdr_idx = '0;
    gather = '0;
    consumed = '0;
    blk_left = '0;
    skip_left = '0;
    desc = '0;
    hold = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_frame_len(32'd0);
    set_frame_len(32'hFFFF_FFFF);

    // magic, descriptor: checksum, single segment, 8-byte content size
    add_row(8'h28, 0, none);
    add_row(8'hB5, 0, none);
    add_row(8'h2F, 0, none);
    add_row(8'hFD, 0, none);
    add_row(8'hE4, 0, none);
    for (int i = 0; i < 7; i++) add_row(8'hFF, 0, none);
    add_row(8'hFF, 1, '{REC_FRAME, 1'b1, 1'b1, 2'd0, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF,
                        44'd0, 32'd0, 2'd0, 2'd0, 2'd0});
    // RLE block of the largest size, one content byte
    add_row(8'hFA, 0, none);
    add_row(8'hFF, 0, none);
    add_row(8'hFF, 1, '{REC_BLOCK, 1'b0, 1'b0, BLK_RLE, 2'd0, 64'h1F_FFFF,
                        44'd0, 32'd0, 2'd0, 2'd0, 2'd0});
    add_row(8'h00, 0, none);
    // compressed block of size zero
    add_row(8'h04, 0, none);
    add_row(8'h00, 0, none);
    add_row(8'h00, 1, '{REC_BLOCK, 1'b0, 1'b0, BLK_COMP, 2'd0, 64'd0,
                        44'd0, 32'd0, 2'd0, 2'd0, 2'd0});
    // compressed block of five: raw literals of two, zero sequences
    add_row(8'h2C, 0, none);
    add_row(8'h00, 0, none);
    add_row(8'h00, 0, none);
    add_row(8'h10, 1, '{REC_LIT, 1'b0, 1'b0, 2'd0, 2'd0, 64'd2,
                        44'd2, 32'd0, 2'd0, 2'd0, 2'd0});
    add_row(8'hAA, 0, none);
    add_row(8'h55, 0, none);
    add_row(8'h00, 1, '{REC_SEQ, 1'b0, 1'b0, 2'd0, 2'd0, 64'd0,
                        44'd0, 32'd0, 2'd0, 2'd0, 2'd0});
    add_row(8'hFF, 0, none);
    foreach (rows[i]) send_word(rows[i].data, rows[i].typed, rows[i].rec);

    for (int p = 0; p < 4; p++) begin
      if (p != 0) set_frame_len(32'h8000_0000 | $urandom());
      idle_pct = pct_idle[p];
      stall_pct = pct_stall[p];
      while (sent < (p + 1) * 275) begin
        if ($urandom_range(99) < 5) begin
          blk_bytes.delete();
          repeat ($urandom_range(1, 4)) blk_bytes.push_back(8'($urandom()));
        end else begin
          gen_block();
        end
        foreach (blk_bytes[i]) send_word(blk_bytes[i], 0, none);
        sent += blk_bytes.size();
      end
    end

    // end the frame: the next block header start drops into the trailer
    idle_pct = 21;
    stall_pct = 21;
    set_frame_len(32'd0);
    for (int k = 0; k < 3; k++) begin
      gen_block();
      foreach (blk_bytes[i]) send_word(blk_bytes[i], 0, none);
    end
    in_if.valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending_recs.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
